FILE: design/egcd_pkg.sv
// Types, microcode encoding and control store for the extended GCD engine.
`timescale 1ns / 1ps

package egcd_pkg;

  // Microprogram addresses
  typedef enum logic [2:0] {
    U_IDLE,
    U_TEST,
    U_DINIT,
    U_DSTEP,
    U_UPDATE,
    U_DONE
  } upc_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DINIT,
    OP_DSTEP,
    OP_UPDATE,
    OP_EMIT
  } uop_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_START,
    JC_RZERO,
    JC_NOTLAST
  } jcond_t;

  // One control word: operation, condition, taken target, fall-through target
  typedef struct packed {
    uop_t   op;
    jcond_t cond;
    upc_t   tgt;
    upc_t   alt;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic r_zero;
    logic cnt_last;
  } egcd_flags_t;

  // Sequencer to datapath
  typedef struct packed {
    uop_t op;
    logic busy;
  } egcd_ctrl_t;

  // Control store
  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    unique case (addr)
      U_IDLE:   w = '{op: OP_LOAD,   cond: JC_START,   tgt: U_TEST,   alt: U_IDLE};
      U_TEST:   w = '{op: OP_NOP,    cond: JC_RZERO,   tgt: U_DONE,   alt: U_DINIT};
      U_DINIT:  w = '{op: OP_DINIT,  cond: JC_ALWAYS,  tgt: U_DSTEP,  alt: U_DSTEP};
      U_DSTEP:  w = '{op: OP_DSTEP,  cond: JC_NOTLAST, tgt: U_DSTEP,  alt: U_UPDATE};
      U_UPDATE: w = '{op: OP_UPDATE, cond: JC_ALWAYS,  tgt: U_TEST,   alt: U_TEST};
      U_DONE:   w = '{op: OP_EMIT,   cond: JC_ALWAYS,  tgt: U_IDLE,   alt: U_IDLE};
      default:  w = '{op: OP_NOP,    cond: JC_ALWAYS,  tgt: U_IDLE,   alt: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/egcd_seq.sv
// Microcode sequencer: program counter, control store lookup, conditional jumps.
`timescale 1ns / 1ps

module egcd_seq
  import egcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  egcd_flags_t flags,
  output egcd_ctrl_t  ctrl
);

  upc_t   upc_r, upc_nxt;
  ucode_t uword;
  logic   taken;

  assign uword = ucode_rom(upc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // next address
  always_comb begin
    unique case (uword.cond)
      JC_ALWAYS:  taken = 1'b1;
      JC_START:   taken = flags.start;
      JC_RZERO:   taken = flags.r_zero;
      JC_NOTLAST: taken = !flags.cnt_last;
      default:    taken = 1'b1;
    endcase
    upc_nxt = taken ? uword.tgt : uword.alt;
  end

  // control outputs
  always_comb begin
    ctrl.op   = uword.op;
    ctrl.busy = (upc_r != U_IDLE);
  end

endmodule

FILE: design/extended_gcd_bezout.sv
// Top level: extended Euclid engine with Bezout coefficients, microcoded control.
`timescale 1ns / 1ps

// Channel    Handshake              Payload
// ---------  ---------------------  ----------------------------------------------
// input      start & !busy          in_operand_a, in_operand_b (unsigned)
// result     out_valid (1 cycle)    out_divisor (unsigned), out_coeff_x/y (signed)
//
// One transaction at a time. Each Euclid step runs a restoring divider over all
// OPERAND_WIDTH dividend bits plus three control steps (init, update, zero test).
// out_valid is high one cycle; busy drops in that same cycle, so the next start
// can be taken while the result is shown. The receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle; data regs are not reset.

module extended_gcd_bezout
  import egcd_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [OPERAND_WIDTH-1:0]        in_operand_a,
  input  logic [OPERAND_WIDTH-1:0]        in_operand_b,
  output logic                            out_valid,
  output logic [OPERAND_WIDTH-1:0]        out_divisor,
  output logic signed [OPERAND_WIDTH:0]   out_coeff_x,
  output logic signed [OPERAND_WIDTH:0]   out_coeff_y
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

  egcd_flags_t flags;
  egcd_ctrl_t  ctrl;

  // remainder pair and coefficient pairs (coefficients mod 2^(W+1))
  logic [W-1:0] r_prev_r, r_cur_r;
  logic [W:0]   s_prev_r, s_cur_r, t_prev_r, t_cur_r;

  // divider state: partial remainder, dividend/quotient shifter, bit count
  logic [W-1:0]     rem_r, dvd_r;
  logic [CNT_W-1:0] cnt_r;
  // running q*s_cur and q*t_cur, built MSB-first as quotient bits come out
  logic [W:0]       acc_s_r, acc_t_r;

  logic [W-1:0]     out_div_r;
  logic [W:0]       out_x_r, out_y_r;
  logic             out_valid_r;

  logic [W:0] trial;
  logic       qbit;

  egcd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign busy = ctrl.busy;

  always_comb begin
    flags.start    = start;
    flags.r_zero   = (r_cur_r == '0);
    flags.cnt_last = (cnt_r == CNT_W'(1));
  end

  // one restoring step: shift in next dividend bit, try subtracting divisor
  assign trial = {rem_r, dvd_r[W-1]} - {1'b0, r_cur_r};
  assign qbit  = !trial[W];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (start) begin
          r_prev_r <= in_operand_a;
          r_cur_r  <= in_operand_b;
          s_prev_r <= (W+1)'(1);
          s_cur_r  <= '0;
          t_prev_r <= '0;
          t_cur_r  <= (W+1)'(1);
        end
      end
      OP_DINIT: begin
        rem_r   <= '0;
        dvd_r   <= r_prev_r;
        cnt_r   <= CNT_W'(W);
        acc_s_r <= '0;
        acc_t_r <= '0;
      end
      OP_DSTEP: begin
        rem_r   <= qbit ? trial[W-1:0] : {rem_r[W-2:0], dvd_r[W-1]};
        dvd_r   <= {dvd_r[W-2:0], qbit};
        cnt_r   <= cnt_r - CNT_W'(1);
        acc_s_r <= {acc_s_r[W-1:0], 1'b0} + (qbit ? s_cur_r : '0);
        acc_t_r <= {acc_t_r[W-1:0], 1'b0} + (qbit ? t_cur_r : '0);
      end
      OP_UPDATE: begin
        r_prev_r <= r_cur_r;
        r_cur_r  <= rem_r;
        s_prev_r <= s_cur_r;
        s_cur_r  <= s_prev_r - acc_s_r;
        t_prev_r <= t_cur_r;
        t_cur_r  <= t_prev_r - acc_t_r;
      end
      OP_EMIT: begin
        out_div_r <= r_prev_r;
        out_x_r   <= s_prev_r;
        out_y_r   <= t_prev_r;
      end
      default: begin
      end
    endcase
  end

  // result strobe: registered from the emit step, high in the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.op == OP_EMIT);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = out_div_r;
  assign out_coeff_x = $signed(out_x_r);
  assign out_coeff_y = $signed(out_y_r);

  // a result is only shown once the sequencer is back in idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction keeps the engine busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  // divider steps never run with an exhausted bit count
  a_dstep_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DSTEP) |-> (cnt_r != '0))
    else $error("divider step with zero count");

  // gcd of zero only for both operands zero, where x is one
  a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_divisor == '0)) |-> (out_coeff_x == (W+1)'(1)))
    else $error("zero gcd with wrong coefficient");

endmodule

FILE: test/extended_gcd_bezout_tb.sv
// Self-checking testbench for extended_gcd_bezout: gcd and Bezout coefficients.
`timescale 1ns / 1ps

// Stimulus:
//   - directed pairs: zero operands, all-ones, equal, a < b, powers of two,
//     the largest 32-bit Fibonacci pair (the longest Euclid chain), big primes
//   - about 350 random pairs mixing uniform words, shared factors, Fibonacci
//     neighbors, small values, zero operands and near-extreme words
// Checking: every transaction accepted on start & !busy is run through an
// iterative Euclid model here, and each out_valid strobe is compared field by
// field with the oldest expectation.
// Sender pacing: 13% idle, then 45% idle, then back-to-back. The result side
// cannot stall, so nothing is done there. A few items wait until the block
// has fully drained before they are offered.

module extended_gcd_bezout_tb;

  localparam int OPERAND_WIDTH = 32;
  localparam int RESET_CYCLES  = 12;
  // worst case: the longest Euclid chain at full operand width, plus margin
  localparam int TAIL_CYCLES   = 1800;
  localparam int RANDOM_PAIRS  = 350;
  // idle phase boundaries, counted in accepted transactions
  localparam int PHASE_LIGHT   = 123;
  localparam int PHASE_HEAVY   = 246;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic signed [OPERAND_WIDTH:0] coeff_t;

  typedef struct {
    operand_t a;
    operand_t b;
    bit       drain;   // hold off until nothing is in flight
  } operand_pair_t;

  typedef struct {
    operand_t divisor;
    coeff_t   coeff_x;
    coeff_t   coeff_y;
  } bezout_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  operand_t in_operand_a = '0;
  operand_t in_operand_b = '0;
  logic     busy;
  logic     out_valid;
  operand_t out_divisor;
  coeff_t   out_coeff_x;
  coeff_t   out_coeff_y;

  operand_pair_t operand_pairs[$];   // items not yet offered
  bezout_t       bezout_due[$];      // expected results, oldest first

  int accepted_count = 0;   // NBA-updated, read by the other processes
  int results_seen   = 0;   // NBA-updated
  int error_count    = 0;
  int drain_pauses   = 0;
  int directed_count = 0;
  bit all_sent       = 1'b0;
  int idle_left      = 0;

  extended_gcd_bezout #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_divisor (out_divisor),
    .out_coeff_x (out_coeff_x),
    .out_coeff_y (out_coeff_y)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Forward Euclid on remainders with running coefficients. The 64-bit
  // coefficient math may wrap; only the low OPERAND_WIDTH+1 bits matter.
  function automatic bezout_t euclid_bezout(input operand_t a, input operand_t b);
    logic [63:0] rem_prev, rem_cur, rem_next, quot;
    logic [63:0] x_prev, x_cur, x_next, y_prev, y_cur, y_next;
    bezout_t     res;
    rem_prev = 64'(a);
    rem_cur  = 64'(b);
    x_prev   = 64'd1;
    x_cur    = 64'd0;
    y_prev   = 64'd0;
    y_cur    = 64'd1;
    while (rem_cur != 64'd0) begin
      quot     = rem_prev / rem_cur;
      rem_next = rem_prev - quot * rem_cur;
      x_next   = x_prev - quot * x_cur;
      y_next   = y_prev - quot * y_cur;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      x_prev   = x_cur;
      x_cur    = x_next;
      y_prev   = y_cur;
      y_cur    = y_next;
    end
    res.divisor = rem_prev[OPERAND_WIDTH-1:0];
    res.coeff_x = x_prev[OPERAND_WIDTH:0];
    res.coeff_y = y_prev[OPERAND_WIDTH:0];
    return res;
  endfunction

  task automatic add_pair(input operand_t a, input operand_t b, input bit drain);
    operand_pair_t p;
    p.a     = a;
    p.b     = b;
    p.drain = drain;
    operand_pairs.push_back(p);
  endtask

  // Driver: records accepted transactions and offers the next pair.
  always @(posedge clk) begin : drive
    operand_pair_t nxt;
    bit            accept_now;
    bit            present;
    int            outstanding;
    int            idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accept_now = start && !busy;
      if (accept_now) begin
        bezout_due.push_back(euclid_bezout(in_operand_a, in_operand_b));
        accepted_count <= accepted_count + 1;
        if (operand_pairs.size() == 0)
          all_sent <= 1'b1;
      end

      idle_pct = (accepted_count < PHASE_LIGHT) ? 13 :
                 (accepted_count < PHASE_HEAVY) ? 45 : 0;
      outstanding = accepted_count + int'(accept_now) - results_seen;
      present = 1'b0;

      if (start && !accept_now) begin
        present = 1'b1;   // keep offering until taken
      end else if (idle_left > 0) begin
        idle_left--;
      end else if (operand_pairs.size() != 0) begin
        if (operand_pairs[0].drain && outstanding != 0) begin
          // waiting for the pipeline to empty
        end else if ($urandom_range(99) < idle_pct) begin
          // mostly short gaps, now and then one long enough to land mid-run
          idle_left = ($urandom_range(9) == 0) ? $urandom_range(800, 40)
                                               : $urandom_range(4, 0);
        end else begin
          nxt = operand_pairs.pop_front();
          in_operand_a <= nxt.a;
          in_operand_b <= nxt.b;
          if (nxt.drain)
            drain_pauses++;
          present = 1'b1;
        end
      end
      start <= present;
    end
  end

  // Monitor: every strobe must match the oldest expectation.
  always @(posedge clk) begin : watch
    bezout_t due;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (bezout_due.size() == 0) begin
        $display("%0t: result with nothing expected: divisor %0d x %0d y %0d",
                 $time, out_divisor, out_coeff_x, out_coeff_y);
        error_count++;
      end else begin
        due = bezout_due.pop_front();
        if (out_divisor !== due.divisor) begin
          $display("%0t: divisor mismatch: expected %0d actual %0d",
                   $time, due.divisor, out_divisor);
          error_count++;
        end
        if (out_coeff_x !== due.coeff_x) begin
          $display("%0t: coeff_x mismatch: expected %0d actual %0d",
                   $time, due.coeff_x, out_coeff_x);
          error_count++;
        end
        if (out_coeff_y !== due.coeff_y) begin
          $display("%0t: coeff_y mismatch: expected %0d actual %0d",
                   $time, due.coeff_y, out_coeff_y);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    operand_t a, b, g, fib_lo, fib_hi, tmp;
    int       steps;
    bit       drain;

    // directed pairs
    add_pair(32'd0, 32'd0, 1'b0);                     // both zero
    add_pair(32'd5, 32'd0, 1'b0);                     // b zero
    add_pair(32'hFFFF_FFFF, 32'd0, 1'b0);
    add_pair(32'd0, 32'd7, 1'b0);                     // a zero, b nonzero
    add_pair(32'd0, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);     // equal, all ones
    add_pair(32'd1, 32'd1, 1'b0);
    add_pair(32'd1234567, 32'd1234567, 1'b0);
    add_pair(32'd3, 32'd10, 1'b0);                    // a < b: first step swaps
    add_pair(32'd10, 32'd3, 1'b0);
    add_pair(32'd12, 32'd18, 1'b0);
    add_pair(32'd2971215073, 32'd1836311903, 1'b0);   // longest Euclid chain
    add_pair(32'd1836311903, 32'd2971215073, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);     // coefficients near the rails
    add_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'h8000_0000, 32'd1, 1'b0);
    add_pair(32'd1, 32'h8000_0000, 1'b0);
    add_pair(32'h8000_0000, 32'h4000_0000, 1'b0);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_pair(32'd4294967291, 32'd4294967279, 1'b0);   // two large primes
    add_pair(32'hFFFF_FFFF, 32'd2, 1'b0);
    directed_count = operand_pairs.size();

    // random pairs; drains at the start, around the phase changes and at pair 300
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      drain = (i == 0) || (i == PHASE_LIGHT - directed_count + 1) ||
              (i == PHASE_HEAVY - directed_count + 1) || (i == 300);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: begin
          a = $urandom;
          b = $urandom;
        end
        7, 8, 9: begin          // shared factor
          g = $urandom_range(65535, 1);
          a = g * operand_t'($urandom_range(65535));
          b = g * operand_t'($urandom_range(65535));
        end
        10, 11: begin           // Fibonacci neighbors, long chains
          fib_lo = 32'd1;
          fib_hi = 32'd1;
          steps  = $urandom_range(45, 1);
          for (int k = 0; k < steps; k++) begin
            tmp    = fib_hi;
            fib_hi = fib_hi + fib_lo;
            fib_lo = tmp;
          end
          a = fib_hi;
          b = fib_lo;
        end
        12, 13: begin           // small values, zeros included
          a = $urandom_range(15);
          b = $urandom_range(15);
        end
        14, 15: begin           // one operand zero
          a = $urandom;
          b = '0;
        end
        16, 17: begin           // a not above b, before the random swap
          a = $urandom;
          b = $urandom;
          if (a > b) begin
            tmp = a;
            a   = b;
            b   = tmp;
          end
        end
        default: begin          // near the extremes, or equal operands
          a = ~operand_t'($urandom_range(255));
          b = ($urandom_range(1) == 0) ? a : operand_t'($urandom);
        end
      endcase
      if ($urandom_range(1) == 0) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      add_pair(a, b, drain);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    do
      @(posedge clk);
    while (!(all_sent && results_seen == accepted_count));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bezout_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, bezout_due.size());
      error_count += bezout_due.size();
    end

    $display("Checked %0d gcd/Bezout transactions (%0d directed, %0d random), %0d results.",
             accepted_count, directed_count, RANDOM_PAIRS, results_seen);
    $display("Sender idle 13%%, 45%%, then none; %0d full-drain pauses.", drain_pauses);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: fails the run if it never finishes.
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: extended_gcd_bezout.f
design/egcd_pkg.sv
design/egcd_seq.sv
design/extended_gcd_bezout.sv
test/extended_gcd_bezout_tb.sv
